[src/kvs_pkg.sv]
package kvs_pkg;

  // fixed field widths of the request and result ports
  localparam int KEY_PORT_W   = 32;
  localparam int VALUE_PORT_W = 32;
  localparam int TIME_W       = 31;
  localparam int STATUS_W     = 2;

  // default table geometry
  localparam int DEF_ENTRIES    = 256;
  localparam int DEF_KEY_BITS   = 32;
  localparam int DEF_VALUE_BITS = 32;

  // request operations
  localparam logic OP_STORE = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_STORED    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // flags from the shared compare unit
  typedef struct packed {
    logic key_eq;
    logic time_eq;
    logic time_le;
    logic time_gt_best;
  } cmp_t;

endpackage

[src/kvs_mem.sv]
module kvs_mem #(
  parameter int AW = 8,
  parameter int W  = 95
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem [(1 << AW)];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/kvs_cmp.sv]
module kvs_cmp #(
  parameter int KEY_W = 32
) (
  input  logic [KEY_W-1:0]          entry_key,
  input  logic [kvs_pkg::TIME_W-1:0] entry_time,
  input  logic [KEY_W-1:0]          req_key,
  input  logic [kvs_pkg::TIME_W-1:0] req_time,
  input  logic [kvs_pkg::TIME_W-1:0] best_time,
  output kvs_pkg::cmp_t             flags
);

  import kvs_pkg::*;

  // key match and the time relations used by store and fetch
  always_comb begin
    flags.key_eq       = (entry_key == req_key);
    flags.time_eq      = (entry_time == req_time);
    flags.time_le      = (entry_time <= req_time);
    flags.time_gt_best = (entry_time > best_time);
  end

endmodule

[src/versioned_key_value_store_core.sv]
// channel   | handshake          | payload
// ----------+--------------------+----------------------------------
// request   | start in, busy out | op, key, value, timestamp
// result    | done strobe out    | status, value_out
//
// A request is taken when start is high and busy is low. Entries fill from
// zero upwards and are never freed, so a fill count marks the valid ones.
// Each request scans the filled entries at one memory read a cycle; on an empty
// table it goes straight to the finish state. Busy falls with done, and reset
// empties the table at once. The result is shown for one cycle with done; the
// receiver cannot stall it.
module versioned_key_value_store_core #(
  parameter int ENTRIES    = kvs_pkg::DEF_ENTRIES,
  parameter int KEY_BITS   = kvs_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = kvs_pkg::DEF_VALUE_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            op,
  input  logic [kvs_pkg::KEY_PORT_W-1:0]   key,
  input  logic [kvs_pkg::VALUE_PORT_W-1:0] value,
  input  logic [kvs_pkg::TIME_W-1:0]       timestamp,
  output logic                            done,
  output logic [kvs_pkg::STATUS_W-1:0]     status,
  output logic [kvs_pkg::VALUE_PORT_W-1:0] value_out
);

  import kvs_pkg::*;

  localparam int AW    = $clog2(ENTRIES);
  localparam int KEY_W = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
  localparam int VAL_W = (VALUE_BITS < VALUE_PORT_W) ? VALUE_BITS : VALUE_PORT_W;
  localparam int WORD_W = KEY_W + TIME_W + VAL_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

  state_t              state;
  logic                req_op;
  logic [KEY_W-1:0]    req_key;
  logic [VAL_W-1:0]    req_val;
  logic [TIME_W-1:0]   req_ts;
  logic [AW:0]         count;
  logic [AW-1:0]       addr;
  logic                issuing;
  logic                rd_pend;
  logic [AW-1:0]       rd_idx;
  logic                hit;
  logic [AW-1:0]       hit_slot;
  logic                found;
  logic [TIME_W-1:0]   best_time;
  logic [VAL_W-1:0]    best_data;

  logic                rd_en;
  logic [WORD_W-1:0]   rd_word;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [KEY_W-1:0]    ent_key;
  logic [TIME_W-1:0]   ent_time;
  logic [VAL_W-1:0]    ent_data;
  logic [AW:0]         count_m1;
  logic [AW-1:0]       last_idx;
  logic                full;
  cmp_t                flags;

  // scan bounds from the fill count
  assign count_m1 = count - (AW + 1)'(1);
  assign last_idx = count_m1[AW-1:0];
  assign full     = (count == (AW + 1)'(ENTRIES));

  // memory access
  assign rd_en   = (state == S_SCAN) && issuing;
  assign wr_en   = (state == S_FINISH) && (req_op == OP_STORE) && (hit || !full);
  assign wr_addr = hit ? hit_slot : count[AW-1:0];
  assign {ent_key, ent_time, ent_data} = rd_word;
  assign busy    = (state != S_IDLE);

  kvs_mem #(
    .AW (AW),
    .W  (WORD_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({req_key, req_ts, req_val}),
    .rd_en   (rd_en),
    .rd_addr (addr),
    .rd_data (rd_word)
  );

  kvs_cmp #(
    .KEY_W (KEY_W)
  ) u_cmp (
    .entry_key  (ent_key),
    .entry_time (ent_time),
    .req_key    (req_key),
    .req_time   (req_ts),
    .best_time  (best_time),
    .flags      (flags)
  );

  // sequencer, scan state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      count   <= '0;
      issuing <= 1'b0;
      rd_pend <= 1'b0;
      hit     <= 1'b0;
      found   <= 1'b0;
    end else begin
      done    <= (state == S_FINISH);
      rd_pend <= rd_en;
      rd_idx  <= addr;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req_op  <= op;
            req_key <= key[KEY_W-1:0];
            req_val <= value[VAL_W-1:0];
            req_ts  <= timestamp;
            hit     <= 1'b0;
            found   <= 1'b0;
            addr    <= '0;
            if (count == '0) begin
              state <= S_FINISH;
            end else begin
              state   <= S_SCAN;
              issuing <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          // issue one read a cycle
          if (issuing) begin
            if (addr == last_idx) begin
              issuing <= 1'b0;
            end else begin
              addr <= addr + AW'(1);
            end
          end
          // compare the entry read last cycle
          if (rd_pend) begin
            if (req_op == OP_STORE) begin
              if (!hit && flags.key_eq && flags.time_eq) begin
                hit      <= 1'b1;
                hit_slot <= rd_idx;
              end
            end else begin
              if (flags.key_eq && flags.time_le && (!found || flags.time_gt_best)) begin
                found     <= 1'b1;
                best_time <= ent_time;
                best_data <= ent_data;
              end
            end
            if (rd_idx == last_idx) begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          state <= S_IDLE;
          if (req_op == OP_STORE) begin
            value_out <= '0;
            if (hit || !full) begin
              status <= ST_STORED;
            end else begin
              status <= ST_FULL;
            end
            if (!hit && !full) begin
              count <= count + (AW + 1)'(1);
            end
          end else begin
            if (found) begin
              status    <= ST_FOUND;
              value_out <= VALUE_PORT_W'(best_data);
            end else begin
              status    <= ST_NOT_FOUND;
              value_out <= '0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[dv/tb.sv]
module tb;
  import kvs_pkg::*;

  localparam int ENTRY_COUNT    = DEF_ENTRIES;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = DEF_ENTRIES + 40;
  localparam int POOL_SIZE      = 6;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [KEY_PORT_W-1:0] KEY_MASK =
    KEY_PORT_W'((64'd1 << DEF_KEY_BITS) - 64'd1);
  localparam logic [VALUE_PORT_W-1:0] VALUE_MASK =
    VALUE_PORT_W'((64'd1 << DEF_VALUE_BITS) - 64'd1);

  // where the expected reply of a request comes from
  typedef enum logic {
    BY_MODEL,
    BY_TABLE
  } check_src_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     st;
    logic [VALUE_PORT_W-1:0] vout;
  } reply_t;

  typedef struct packed {
    logic                    req_op;
    logic [KEY_PORT_W-1:0]   req_key;
    logic [VALUE_PORT_W-1:0] req_value;
    logic [TIME_W-1:0]       req_ts;
    check_src_t              src;
    logic [STATUS_W-1:0]     st;
    logic [VALUE_PORT_W-1:0] vout;
  } stim_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    op = OP_STORE;
  logic [KEY_PORT_W-1:0]   key = '0;
  logic [VALUE_PORT_W-1:0] value = '0;
  logic [TIME_W-1:0]       timestamp = '0;
  logic                    done;
  logic [STATUS_W-1:0]     status;
  logic [VALUE_PORT_W-1:0] value_out;

  // own copy of the version table
  bit                      tab_valid [ENTRY_COUNT];
  logic [KEY_PORT_W-1:0]   tab_key   [ENTRY_COUNT];
  logic [TIME_W-1:0]       tab_time  [ENTRY_COUNT];
  logic [VALUE_PORT_W-1:0] tab_data  [ENTRY_COUNT];
  int                      slots_used = 0;

  reply_t                  due_replies [$];
  int                      fail_count = 0;
  int                      quiet_cycles = 0;
  int                      idle_pct = 0;
  logic [KEY_PORT_W-1:0]   key_pool [POOL_SIZE];

  // directed requests: extremes, overwrite, version lookup, misses
  stim_row_t directed_rows [0:18] = '{
    '{OP_FETCH, 32'h0000_0000, 32'h0000_0000, TIME_MAX,      BY_TABLE, ST_NOT_FOUND, 32'h0},
    '{OP_STORE, 32'h0000_0000, 32'h0000_0000, 31'h0,         BY_TABLE, ST_STORED,    32'h0},
    '{OP_STORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, TIME_MAX,      BY_TABLE, ST_STORED,    32'h0},
    '{OP_FETCH, 32'hFFFF_FFFF, 32'h0000_0000, TIME_MAX,      BY_TABLE, ST_FOUND,
      32'hFFFF_FFFF},
    '{OP_FETCH, 32'hFFFF_FFFF, 32'h1234_5678, 31'h7FFF_FFFE, BY_TABLE, ST_NOT_FOUND, 32'h0},
    '{OP_FETCH, 32'h0000_0000, 32'h0000_0000, 31'h0,         BY_TABLE, ST_FOUND,     32'h0},
    '{OP_STORE, 32'h0000_0000, 32'hA5A5_A5A5, 31'h0,         BY_TABLE, ST_STORED,    32'h0},
    '{OP_FETCH, 32'h0000_0000, 32'hFFFF_FFFF, TIME_MAX,      BY_TABLE, ST_FOUND,
      32'hA5A5_A5A5},
    '{OP_STORE, 32'h0000_1234, 32'h0000_0100, 31'd10,        BY_MODEL, ST_STORED,    32'h0},
    '{OP_STORE, 32'h0000_1234, 32'h0000_0200, 31'd20,        BY_MODEL, ST_STORED,    32'h0},
    '{OP_STORE, 32'h0000_1234, 32'h0000_0300, 31'd30,        BY_MODEL, ST_STORED,    32'h0},
    '{OP_FETCH, 32'h0000_1234, 32'h0000_0000, 31'd25,        BY_MODEL, ST_STORED,    32'h0},
    '{OP_FETCH, 32'h0000_1234, 32'h0000_0000, 31'd9,         BY_TABLE, ST_NOT_FOUND, 32'h0},
    '{OP_FETCH, 32'h0000_1234, 32'h0000_0000, 31'd30,        BY_MODEL, ST_STORED,    32'h0},
    '{OP_FETCH, 32'h0000_1235, 32'h0000_0000, 31'd30,        BY_TABLE, ST_NOT_FOUND, 32'h0},
    '{OP_STORE, 32'h0000_1234, 32'h5A5A_5A5A, 31'd20,        BY_MODEL, ST_STORED,    32'h0},
    '{OP_FETCH, 32'h0000_1234, 32'h0000_0000, 31'd29,        BY_MODEL, ST_STORED,    32'h0},
    '{OP_STORE, 32'h8000_0000, 32'h8000_0001, 31'h4000_0000, BY_MODEL, ST_STORED,    32'h0},
    '{OP_FETCH, 32'h8000_0000, 32'h0000_0000, TIME_MAX,      BY_MODEL, ST_STORED,    32'h0}
  };

  versioned_key_value_store_core DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .op        (op),
    .key       (key),
    .value     (value),
    .timestamp (timestamp),
    .done      (done),
    .status    (status),
    .value_out (value_out)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // expected reply of one request, updating the table copy
  function automatic reply_t table_lookup_update(input logic req_op,
      input logic [KEY_PORT_W-1:0] req_key, input logic [VALUE_PORT_W-1:0] req_value,
      input logic [TIME_W-1:0] req_ts);
    reply_t                  reply;
    int                      hit_slot;
    int                      free_slot;
    bit                      found;
    logic [TIME_W-1:0]       best_time;
    logic [KEY_PORT_W-1:0]   k;
    logic [VALUE_PORT_W-1:0] v;
    k = req_key & KEY_MASK;
    v = req_value & VALUE_MASK;
    reply.vout = '0;
    if (req_op == OP_STORE) begin
      hit_slot = -1;
      free_slot = -1;
      for (int i = 0; i < ENTRY_COUNT; i++) begin
        if (tab_valid[i]) begin
          if (hit_slot < 0 && tab_key[i] == k && tab_time[i] == req_ts) hit_slot = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (hit_slot >= 0) begin
        tab_data[hit_slot] = v;
        reply.st = ST_STORED;
      end else if (free_slot >= 0) begin
        tab_valid[free_slot] = 1'b1;
        tab_key[free_slot] = k;
        tab_time[free_slot] = req_ts;
        tab_data[free_slot] = v;
        slots_used++;
        reply.st = ST_STORED;
      end else begin
        reply.st = ST_FULL;
      end
    end else begin
      found = 1'b0;
      best_time = '0;
      for (int i = 0; i < ENTRY_COUNT; i++) begin
        if (tab_valid[i] && tab_key[i] == k && tab_time[i] <= req_ts) begin
          if (!found || tab_time[i] > best_time) begin
            found = 1'b1;
            best_time = tab_time[i];
            reply.vout = tab_data[i];
          end
        end
      end
      reply.st = found ? ST_FOUND : ST_NOT_FOUND;
    end
    return reply;
  endfunction

  // present one request, wait for it to be taken, then record its reply
  task automatic send_request(input logic req_op, input logic [KEY_PORT_W-1:0] req_key,
      input logic [VALUE_PORT_W-1:0] req_value, input logic [TIME_W-1:0] req_ts,
      input check_src_t src, input reply_t fixed);
    reply_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    op        <= req_op;
    key       <= req_key;
    value     <= req_value;
    timestamp <= req_ts;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = table_lookup_update(req_op, req_key, req_value, req_ts);
    due_replies = {due_replies, ((src == BY_TABLE) ? fixed : predicted)};
  endtask

  // sender holds off until every outstanding reply has come back
  task automatic drain_replies;
    start <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk);
  endtask

  // random request, biased towards keys and times already in the table
  task automatic random_request(input int store_pct, input bit exact_version);
    logic                  req_op;
    logic [KEY_PORT_W-1:0] req_key;
    logic [TIME_W-1:0]     req_ts;
    int                    pick;
    int                    slot;
    req_op = ($urandom_range(99) < store_pct) ? OP_STORE : OP_FETCH;
    slot = (slots_used > 0) ? $urandom_range(slots_used - 1) : 0;
    pick = $urandom_range(99);
    if (pick < 60) req_key = key_pool[$urandom_range(POOL_SIZE - 1)];
    else if (pick < 85 && slots_used > 0) req_key = tab_key[slot];
    else req_key = $urandom;
    pick = $urandom_range(99);
    if (pick < 55) req_ts = TIME_W'($urandom_range(15));
    else if (pick < 80 && slots_used > 0) req_ts = tab_time[slot] + TIME_W'($urandom_range(2)) - 1'b1;
    else if (pick < 95) req_ts = TIME_W'($urandom);
    else req_ts = TIME_MAX;
    // exact existing version: overwrite in place
    if (exact_version && slots_used > 0) begin
      req_op = OP_STORE;
      req_key = tab_key[slot];
      req_ts = tab_time[slot];
    end
    send_request(req_op, req_key, $urandom, req_ts, BY_MODEL, '0);
  endtask

  // result checking and watchdog
  always @(posedge clk) begin
    reply_t want;
    if (!rst) begin
      if (done) begin
        if (due_replies.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d value_out %h",
                   $time, status, value_out);
          fail_count++;
        end else begin
          want = due_replies.pop_front();
          if (status !== want.st) begin
            $display("%0t: status mismatch, expected %0d, actual %0d", $time, want.st, status);
            fail_count++;
          end
          if (value_out !== want.vout) begin
            $display("%0t: value_out mismatch, expected %h, actual %h",
                     $time, want.vout, value_out);
            fail_count++;
          end
        end
      end
      if ((start && !busy) || done) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no request or result for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    reply_t fixed;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table
    idle_pct = 0;
    for (int r = 0; r < $size(directed_rows); r++) begin
      fixed.st = directed_rows[r].st;
      fixed.vout = directed_rows[r].vout;
      send_request(directed_rows[r].req_op, directed_rows[r].req_key,
                   directed_rows[r].req_value, directed_rows[r].req_ts,
                   directed_rows[r].src, fixed);
    end
    drain_replies();

    // mixed traffic, back to back
    idle_pct = 0;
    repeat (150) random_request(55, 1'b0);
    drain_replies();

    // mixed traffic, sender mostly idle
    idle_pct = 62;
    repeat (150) random_request(50, 1'b0);
    drain_replies();

    // fill the table with fresh versions, fetches in between
    idle_pct = 20;
    while (slots_used < ENTRY_COUNT) begin
      if ($urandom_range(3) == 0) random_request(0, 1'b0);
      else send_request(OP_STORE, $urandom, $urandom, TIME_W'($urandom), BY_MODEL, '0);
    end
    drain_replies();

    // full table: drops, in-place overwrites and fetches
    for (int chunk = 0; chunk < 3; chunk++) begin
      idle_pct = (chunk == 0) ? 62 : (chunk == 1) ? 0 : 20;
      for (int n = 0; n < 50; n++) random_request(50, n % 3 == 0);
    end

    // wait out the last replies and any trailing activity
    start <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[versioned_key_value_store_core.f]
src/kvs_pkg.sv
src/kvs_mem.sv
src/kvs_cmp.sv
src/versioned_key_value_store_core.sv
dv/tb.sv
